/* src/cpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_pkg - shared types and constants for the contiguous prefix gate
// Item layouts, command codes and the control word of the sorted cell chain.
// ----------------------------------------------------------------------------
package cpg_pkg;

	localparam int CTR_W         = 32;   // counter part of a sequence value
	localparam int SEQ_W         = 64;   // term and counter
	localparam int CMD_W         = 2;
	localparam int GAPS_W        = 10;   // width of the reported gap count
	localparam int GAP_DEPTH_DEF = 512;
	localparam int OR_FAN        = 16;   // fan-in of one duplicate tree level

	localparam logic [CMD_W-1:0] CMD_NEW   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SYNC  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [SEQ_W-1:0] seq_value;
	} in_item_t;

	typedef struct packed {
		logic [CTR_W-1:0]  prefix_now;
		logic              released;
		logic [SEQ_W-1:0]  release_target;
		logic [GAPS_W-1:0] gaps_held;
		logic              overflowed;
	} out_item_t;

	// HOLD: keep; CMP: latch compare flags; INS: sorted insert; POP: shift to head
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_CMP,
		OP_INS,
		OP_POP
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [CTR_W-1:0] key;
	} cell_ctrl_t;

endpackage

/* src/cpg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_if - valid/ready channels of the contiguous prefix gate
// One interface for input items, one for result items.
// ----------------------------------------------------------------------------
interface cpg_in_if;
	import cpg_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cpg_out_if;
	import cpg_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* src/cpg_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_cell - one slot of the sorted gap chain
// Holds one counter, compares it with the broadcast key and trades values
// with its neighbors on insert and pop.
// ----------------------------------------------------------------------------
module cpg_cell #(
	parameter int IDX    = 0,
	parameter int FILL_W = 10
) (
	input  logic                     clk,
	input  cpg_pkg::cell_ctrl_t      ctrl,
	input  logic [FILL_W-1:0]        fill,
	input  logic [cpg_pkg::CTR_W-1:0] prev_val,
	input  logic                     prev_lt,
	input  logic [cpg_pkg::CTR_W-1:0] next_val,
	output logic [cpg_pkg::CTR_W-1:0] val,
	output logic                     lt,
	output logic                     eq
);
	import cpg_pkg::*;

	logic [CTR_W-1:0] val_q;
	logic             lt_q;
	logic             eq_q;
	logic             occ;

	// slot holds a live counter when it lies below the fill count
	assign occ = fill > FILL_W'(IDX);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_CMP: begin
				lt_q <= occ && (val_q < ctrl.key);
				eq_q <= occ && (val_q == ctrl.key);
			end
			OP_INS: begin
				// first slot not below the key takes it, later ones shift up
				if (!lt_q) begin
					val_q <= prev_lt ? ctrl.key : prev_val;
				end
			end
			OP_POP: begin
				val_q <= next_val;
			end
			default: begin
			end
		endcase
	end

	assign val = val_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

/* src/cpg_or_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_or_tree - registered OR reduction of the per-slot match flags
// Two register levels of fixed fan-in, final OR taken after the second.
// ----------------------------------------------------------------------------
module cpg_or_tree #(
	parameter int N = 512
) (
	input  logic         clk,
	input  logic [N-1:0] bits,
	output logic         any
);
	import cpg_pkg::*;

	localparam int N1 = (N + OR_FAN - 1) / OR_FAN;
	localparam int N2 = (N1 + OR_FAN - 1) / OR_FAN;

	logic [N1*OR_FAN-1:0] pad1;
	logic [N2*OR_FAN-1:0] pad2;
	logic [N1-1:0]        l1_q;
	logic [N2-1:0]        l2_q;

	always_comb begin
		pad1        = '0;
		pad1[N-1:0] = bits;
		pad2         = '0;
		pad2[N1-1:0] = l1_q;
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < N1; g++) begin
			l1_q[g] <= |pad1[g*OR_FAN +: OR_FAN];
		end
		for (int g = 0; g < N2; g++) begin
			l2_q[g] <= |pad2[g*OR_FAN +: OR_FAN];
		end
	end

	assign any = |l2_q;

endmodule

/* src/contiguous_prefix_gate_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_prefix_gate_core - contiguous sequence prefix tracker with gate
// Follows the highest counter k with 1..k all seen, holds out-of-order
// counters in a sorted cell chain, and releases a waiting batch at a target.
// ----------------------------------------------------------------------------
// One item at a time. A sync answer, flush, ignored arrival or undefined
// command goes from acceptance straight to the result load. An out-of-order
// counter passes the broadcast compare in every cell, two register levels of
// the duplicate OR tree, the shift-insert, the gate check and the result
// load; a drop on a full store passes only the gate check and result load.
// An in-order counter drains the buffered counters that continue the prefix,
// the chain popping one counter from its head per cycle, before the gate
// check and the result load. The next item is taken while the previous
// result waits on the output register. The gap store needs no clearing
// after reset: the fill count marks which cells hold counters.
// ----------------------------------------------------------------------------
module contiguous_prefix_gate_core #(
	parameter int GAP_DEPTH = cpg_pkg::GAP_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cpg_in_if.sink     item,
	cpg_out_if.source  result
);
	import cpg_pkg::*;

	localparam int FILL_W = $clog2(GAP_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_OR1,
		S_OR2,
		S_WR,
		S_DRAIN,
		S_GATE,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [CTR_W-1:0]  prefix_q;     // contiguous prefix
	logic [FILL_W-1:0] fill_q;       // number of cells holding a counter
	logic [SEQ_W-1:0]  goal_q;       // sync target, zero = none
	logic [CTR_W-1:0]  key_q;        // counter broadcast to the chain
	logic              rel_q;
	logic [SEQ_W-1:0]  tgt_q;
	logic              ovf_q;
	logic              out_valid_q;
	out_item_t         out_q;

	// chain wiring
	logic [CTR_W-1:0]     cell_val [GAP_DEPTH];
	logic [GAP_DEPTH-1:0] cell_lt;
	logic [GAP_DEPTH-1:0] cell_eq;
	cell_ctrl_t           ctrl;
	logic                 dup;

	logic [CTR_W-1:0] in_ctr;
	logic [SEQ_W-1:0] in_seq;
	logic [CTR_W-1:0] prefix_inc;
	logic [CTR_W-1:0] head;
	logic             pop;
	logic             full;

	assign in_seq     = item.data.seq_value;
	assign in_ctr     = in_seq[CTR_W-1:0];
	assign prefix_inc = prefix_q + CTR_W'(1);
	assign head       = cell_val[0];
	// the head of the sorted chain continues the prefix
	assign pop        = (fill_q != '0) && (head == prefix_inc);
	assign full       = fill_q == FILL_W'(GAP_DEPTH);

	assign item.ready   = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	always_comb begin
		ctrl.key = key_q;
		case (state_q)
			S_CMP:   ctrl.op = OP_CMP;
			S_WR:    ctrl.op = dup ? OP_HOLD : OP_INS;
			S_DRAIN: ctrl.op = pop ? OP_POP : OP_HOLD;
			default: ctrl.op = OP_HOLD;
		endcase
	end

	// sorted chain, ascending from cell 0
	for (genvar i = 0; i < GAP_DEPTH; i++) begin : g_cell
		logic [CTR_W-1:0] prev_val;
		logic             prev_lt;
		logic [CTR_W-1:0] next_val;

		if (i == 0) begin : g_first
			assign prev_val = '0;
			assign prev_lt  = 1'b1;   // nothing ahead of the head cell
		end else begin : g_mid
			assign prev_val = cell_val[i-1];
			assign prev_lt  = cell_lt[i-1];
		end

		if (i == GAP_DEPTH - 1) begin : g_last
			assign next_val = '0;
		end else begin : g_body
			assign next_val = cell_val[i+1];
		end

		cpg_cell #(
			.IDX    (i),
			.FILL_W (FILL_W)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.fill     (fill_q),
			.prev_val (prev_val),
			.prev_lt  (prev_lt),
			.next_val (next_val),
			.val      (cell_val[i]),
			.lt       (cell_lt[i]),
			.eq       (cell_eq[i])
		);
	end

	// duplicate detect, registered through both OR tree levels after the compare
	cpg_or_tree #(
		.N (GAP_DEPTH)
	) u_dup_tree (
		.clk  (clk),
		.bits (cell_eq),
		.any  (dup)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prefix_q    <= '0;
			fill_q      <= '0;
			goal_q      <= '0;
			key_q       <= '0;
			rel_q       <= 1'b0;
			tgt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// S_FIN handles the output register itself
			if (out_valid_q && result.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						key_q   <= in_ctr;
						rel_q   <= 1'b0;
						tgt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_FIN;
						case (item.data.cmd)
							CMD_NEW: begin
								// zero and stale counters are ignored, no gate check
								if (in_seq != '0 && in_ctr > prefix_q) begin
									if (in_ctr == prefix_inc) begin
										prefix_q <= in_ctr;
										state_q  <= S_DRAIN;
									end else if (full) begin
										ovf_q   <= 1'b1;
										state_q <= S_GATE;
									end else begin
										state_q <= S_CMP;
									end
								end
							end
							CMD_SYNC: begin
								if (in_seq == '0) begin
									rel_q  <= 1'b1;
									goal_q <= '0;
								end else if (prefix_q >= in_ctr) begin
									rel_q  <= 1'b1;
									tgt_q  <= in_seq;
									goal_q <= '0;
								end else begin
									goal_q <= in_seq;
								end
							end
							CMD_FLUSH: begin
								goal_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_CMP: state_q <= S_OR1;
				S_OR1: state_q <= S_OR2;
				S_OR2: state_q <= S_WR;
				S_WR: begin
					if (!dup) begin
						fill_q <= fill_q + FILL_W'(1);
					end
					state_q <= S_GATE;
				end
				S_DRAIN: begin
					if (pop) begin
						prefix_q <= head;
						fill_q   <= fill_q - FILL_W'(1);
					end else begin
						state_q <= S_GATE;
					end
				end
				S_GATE: begin
					if (goal_q != '0 && prefix_q >= goal_q[CTR_W-1:0]) begin
						rel_q  <= 1'b1;
						tgt_q  <= goal_q;
						goal_q <= '0;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || result.ready) begin
						out_q.prefix_now     <= prefix_q;
						out_q.released       <= rel_q;
						out_q.release_target <= tgt_q;
						out_q.gaps_held      <= GAPS_W'(fill_q);
						out_q.overflowed     <= ovf_q;
						out_valid_q          <= 1'b1;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/cpg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_checker - port-level checks of the contiguous prefix gate
// Tracks items in flight and the last delivered prefix; bound to the core.
// ----------------------------------------------------------------------------
module cpg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input cpg_pkg::out_item_t out_data
);
	import cpg_pkg::*;

	logic             in_acc;
	logic             out_acc;
	logic [1:0]       pending_q;
	logic             seen_q;
	logic [CTR_W-1:0] last_prefix_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= '0;
			seen_q        <= 1'b0;
			last_prefix_q <= '0;
		end else begin
			if (in_acc && !out_acc) begin
				pending_q <= pending_q + 2'd1;
			end else if (!in_acc && out_acc) begin
				pending_q <= pending_q - 2'd1;
			end
			if (out_acc) begin
				seen_q        <= 1'b1;
				last_prefix_q <= out_data.prefix_now;
			end
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// no result without an item behind it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result with no item outstanding");

	// one item in work at most, beside one waiting result
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> pending_q == 2'd0 || pending_q == 2'd1)
		else $error("item taken with too many outstanding");

	// the prefix never moves back
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q |-> out_data.prefix_now >= last_prefix_q)
		else $error("prefix decreased");

endmodule

bind contiguous_prefix_gate_core cpg_checker u_cpg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
